// ===== rtl/i2c_master_register_access_top_defines.svh =====
// Assertion helpers for the I2C register access block.
`ifndef I2C_MASTER_REGISTER_ACCESS_TOP_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define I2CMRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define I2CMRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define I2CMRA_ASSERT_NXT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/i2cmra_pkg.sv =====
`default_nettype none
package i2cmra_pkg;

  typedef logic [3:0] seg_t;

  // bus segments
  localparam seg_t SEG_START  = 4'd0;
  localparam seg_t SEG_ADDR_W = 4'd1;
  localparam seg_t SEG_ADDR_R = 4'd2;
  localparam seg_t SEG_REG    = 4'd3;
  localparam seg_t SEG_DATA   = 4'd4;
  localparam seg_t SEG_ACK    = 4'd5;
  localparam seg_t SEG_RECV   = 4'd6;
  localparam seg_t SEG_NACK   = 4'd7;
  localparam seg_t SEG_STOP   = 4'd8;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // last plan index of each transaction type
  localparam logic [3:0] WR_LAST_IDX = 4'd7;
  localparam logic [3:0] RD_LAST_IDX = 4'd10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       nack_seen;
  } res_t;

  // Segment at plan position idx.
  function automatic seg_t plan_seg(input logic is_read, input logic [3:0] idx);
    seg_t s;
    s = SEG_STOP;
    if (is_read) begin
      case (idx)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_ADDR_W;
        4'd2:    s = SEG_ACK;
        4'd3:    s = SEG_REG;
        4'd4:    s = SEG_ACK;
        4'd5:    s = SEG_START;
        4'd6:    s = SEG_ADDR_R;
        4'd7:    s = SEG_ACK;
        4'd8:    s = SEG_RECV;
        4'd9:    s = SEG_NACK;
        default: s = SEG_STOP;
      endcase
    end else begin
      case (idx)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_ADDR_W;
        4'd2:    s = SEG_ACK;
        4'd3:    s = SEG_REG;
        4'd4:    s = SEG_ACK;
        4'd5:    s = SEG_DATA;
        4'd6:    s = SEG_ACK;
        default: s = SEG_STOP;
      endcase
    end
    return s;
  endfunction

  // Offset of the final phase in a segment.
  function automatic logic [4:0] seg_last_off(input seg_t s);
    logic [4:0] r;
    r = 5'd2;
    case (s) inside
      SEG_START:                                  r = 5'd3;
      SEG_ADDR_W, SEG_ADDR_R, SEG_REG, SEG_DATA:  r = 5'd23;
      SEG_RECV:                                   r = 5'd16;
      default:                                    r = 5'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i2cmra_ifs.sv =====
`default_nettype none
interface i2cmra_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic       sda_sample;

  modport source (output valid, command, reg_address, write_data, sda_sample,
                  input ready);
  modport sink (input valid, command, reg_address, write_data, sda_sample,
                output ready);
endinterface

interface i2cmra_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       nack_seen;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                  nack_seen, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                nack_seen, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2cmra_in_stage.sv =====
`default_nettype none
module i2cmra_in_stage import i2cmra_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire in_item_t up_item,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output in_item_t      dn_item
);

  logic     vld_r;
  in_item_t item_r;

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2cmra_engine.sv =====
`default_nettype none
module i2cmra_engine import i2cmra_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [6:0] dev_addr,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire in_item_t   item,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res
);

  logic       busy_r, busy_nxt;
  logic       op_read_r, op_read_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [4:0] off_r, off_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [7:0] lat_reg_r, lat_reg_nxt;
  logic [7:0] lat_data_r, lat_data_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] rcv_r, rcv_nxt;
  logic       nack_r, nack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       res_valid_r;
  res_t       res_r, res_nxt;

  logic       take, start, run, last, seg_end;
  logic [3:0] idx;
  logic [4:0] off;
  logic [1:0] sub;
  logic [7:0] byte_src, cur_shift;
  seg_t       seg;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_comb begin
    start = !busy_r && (item.command == CMD_WRITE || item.command == CMD_READ);
    run   = busy_r || start;

    op_read_nxt  = start ? (item.command == CMD_READ) : op_read_r;
    lat_reg_nxt  = start ? item.reg_address : lat_reg_r;
    lat_data_nxt = start ? item.write_data  : lat_data_r;
    idx          = start ? 4'd0 : idx_r;
    off          = start ? 5'd0 : off_r;
    sub          = start ? 2'd0 : sub_r;

    seg     = plan_seg(op_read_nxt, idx);
    seg_end = (off == seg_last_off(seg));
    last    = seg_end && (idx == (op_read_nxt ? RD_LAST_IDX : WR_LAST_IDX));

    case (seg)
      SEG_ADDR_W: byte_src = {dev_addr, 1'b0};
      SEG_ADDR_R: byte_src = {dev_addr, 1'b1};
      SEG_REG:    byte_src = lat_reg_nxt;
      default:    byte_src = lat_data_nxt;
    endcase
    cur_shift = (off == 5'd0) ? byte_src : shift_r;

    nack_nxt  = start ? 1'b0 : nack_r;
    shift_nxt = shift_r;
    rcv_nxt   = rcv_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    idx_nxt   = idx_r;
    off_nxt   = off_r;
    sub_nxt   = sub_r;
    busy_nxt  = busy_r;

    if (run) begin
      busy_nxt = !last;
      if (seg_end) begin
        idx_nxt = idx + 4'd1;
        off_nxt = 5'd0;
        sub_nxt = 2'd0;
      end else begin
        idx_nxt = idx;
        off_nxt = off + 5'd1;
        sub_nxt = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
      end

      unique case (seg) inside
        SEG_START: begin
          case (off[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        SEG_ADDR_W, SEG_ADDR_R, SEG_REG, SEG_DATA: begin
          case (sub)
            2'd0: begin
              sda_nxt   = cur_shift[7];
              shift_nxt = cur_shift;
            end
            2'd1:    scl_nxt = 1'b1;
            default: begin
              scl_nxt   = 1'b0;
              shift_nxt = {cur_shift[6:0], 1'b0};
            end
          endcase
        end
        SEG_ACK: begin
          if (off == 5'd0) begin
            sda_nxt = 1'b1;
          end else if (off == 5'd1) begin
            scl_nxt = 1'b1;
            if (item.sda_sample) nack_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        SEG_RECV: begin
          if (off == 5'd0) begin
            sda_nxt   = 1'b1;
            shift_nxt = 8'd0;
          end else if (off[0]) begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[6:0], item.sda_sample};
          end else begin
            scl_nxt = 1'b0;
            if (off == 5'd16) rcv_nxt = shift_r;
          end
        end
        SEG_NACK: begin
          if (off == 5'd0)      sda_nxt = 1'b1;
          else if (off == 5'd1) scl_nxt = 1'b1;
          else                  scl_nxt = 1'b0;
        end
        default: begin
          // stop
          if (off == 5'd0)      sda_nxt = 1'b0;
          else if (off == 5'd1) scl_nxt = 1'b1;
          else                  sda_nxt = 1'b1;
        end
      endcase
    end

    res_nxt.scl_level = scl_nxt;
    res_nxt.sda_level = sda_nxt;
    res_nxt.busy_res  = busy_nxt;
    res_nxt.done_res  = run && last;
    res_nxt.read_byte = rcv_nxt;
    res_nxt.nack_seen = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      op_read_r   <= 1'b0;
      idx_r       <= 4'd0;
      off_r       <= 5'd0;
      sub_r       <= 2'd0;
      lat_reg_r   <= 8'd0;
      lat_data_r  <= 8'd0;
      shift_r     <= 8'd0;
      rcv_r       <= 8'd0;
      nack_r      <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      res_valid_r <= 1'b0;
    end else begin
      if (item_ready) res_valid_r <= item_valid;
      if (take) begin
        busy_r     <= busy_nxt;
        op_read_r  <= op_read_nxt;
        idx_r      <= idx_nxt;
        off_r      <= off_nxt;
        sub_r      <= sub_nxt;
        lat_reg_r  <= lat_reg_nxt;
        lat_data_r <= lat_data_nxt;
        shift_r    <= shift_nxt;
        rcv_r      <= rcv_nxt;
        nack_r     <= nack_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/i2c_master_register_access_top.sv =====
`default_nettype none
// I2C master for single register writes and reads. Every input item is one bus
// phase tick: command 1 (write) or 2 (read) starts a transaction when idle,
// while busy any other item advances the bus by one phase, and every item
// yields exactly one result item with the SCL/SDA drive levels (1 = release),
// busy, a done pulse on the phase that ends the stop condition, the last read
// byte and a missing-acknowledge flag. A write runs 88 ticks, a read 112 (the
// read closes with a master NACK before stop). Commands while busy are
// ignored. Throughput is one item per clock when not stalled; each item passes
// the input register and the phase engine, which updates the bus state and
// loads the result register. The 7-bit target address is written through
// cfg_we/cfg_wdata and should only change while no transaction is running.
module i2c_master_register_access_top import i2cmra_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  i2cmra_in_if.sink       in_ch,
  i2cmra_out_if.source    out_ch,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);

  logic [6:0] dev_addr_r;
  in_item_t   in_item, st_item;
  logic       st_valid, st_ready;
  res_t       res;

  // target address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 7'd0;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_wdata;
    end
  end

  assign in_item.command     = in_ch.command;
  assign in_item.reg_address = in_ch.reg_address;
  assign in_item.write_data  = in_ch.write_data;
  assign in_item.sda_sample  = in_ch.sda_sample;

  // input register
  i2cmra_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_item  (in_item),
    .dn_valid (st_valid),
    .dn_ready (st_ready),
    .dn_item  (st_item)
  );

  // phase engine and result register
  i2cmra_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .dev_addr   (dev_addr_r),
    .item_valid (st_valid),
    .item_ready (st_ready),
    .item       (st_item),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.scl_level = res.scl_level;
  assign out_ch.sda_level = res.sda_level;
  assign out_ch.busy_res  = res.busy_res;
  assign out_ch.done_res  = res.done_res;
  assign out_ch.read_byte = res.read_byte;
  assign out_ch.nack_seen = res.nack_seen;

endmodule
`default_nettype wire

// ===== rtl/i2cmra_checker.sv =====
`default_nettype none
`include "i2c_master_register_access_top_defines.svh"
module i2cmra_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_scl,
  input wire logic       out_sda,
  input wire logic       out_busy,
  input wire logic       out_done,
  input wire logic [7:0] out_rbyte,
  input wire logic       out_nack
);

  // no result right after reset
  `I2CMRA_ASSERT_NXT_RST(a_rst_empty, clk, !rst_n, !out_valid, "result valid after reset")

  // stalled result holds
  `I2CMRA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_scl, out_sda, out_busy, out_done, out_rbyte, out_nack}), "stalled result changed")

  // done ends the transaction with both lines released
  `I2CMRA_ASSERT_IMP(a_done_idle, clk, rst_n, out_valid && out_done, !out_busy && out_scl && out_sda, "done without idle bus")

endmodule

bind i2c_master_register_access_top i2cmra_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_scl   (out_ch.scl_level),
  .out_sda   (out_ch.sda_level),
  .out_busy  (out_ch.busy_res),
  .out_done  (out_ch.done_res),
  .out_rbyte (out_ch.read_byte),
  .out_nack  (out_ch.nack_seen)
);
`default_nettype wire
